// ===== hw/rtl/wts_pkg.sv =====
// Shared constants and byte classification and lowering functions for the word tokenizer.
`default_nettype none

package wts_pkg;

	// Default word buffer capacity; the buffer holds one byte less than this.
	localparam int WORD_CAPACITY_DEF = 32;

	// Words of this many bytes or fewer are discarded.
	localparam int MIN_TOKEN_BYTES = 2;

	// Field widths fixed by the interface.
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;

	// Reset value of the token limit register.
	localparam logic [COUNT_W-1:0] TOKEN_LIMIT_RST = 16'hFFFF;

	// Bytes at or above this value count as word bytes.
	localparam logic [BYTE_W-1:0] HIGH_BYTE_MARK = 8'h80;

	// Byte that ends the text.
	localparam logic [BYTE_W-1:0] TEXT_END_BYTE = 8'h00;

	// Result kinds.
	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_END   = 1'b1;

	// True for ASCII letters and digits and for any byte with the top bit set.
	function automatic logic is_word_byte(input logic [BYTE_W-1:0] b);
		logic digit;
		logic upper;
		logic lower;
		digit = (b >= 8'h30) && (b <= 8'h39);
		upper = (b >= 8'h41) && (b <= 8'h5A);
		lower = (b >= 8'h61) && (b <= 8'h7A);
		return digit || upper || lower || (b >= HIGH_BYTE_MARK);
	endfunction

	// Lowers an ASCII upper case letter; every other byte passes unchanged.
	function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		r = b;
		if ((b >= 8'h41) && (b <= 8'h5A)) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/word_tokenizer_stream_core.sv =====
// Top level of the streaming word tokenizer.
//
// Usage: text bytes enter on the text channel (text_valid, text_stall,
// text_byte), one item per byte. Letters and digits, lowered, and bytes of
// 0x80 and above collect into a word buffer of WORD_CAPACITY-1 bytes; any
// other byte ends the word, and a zero byte also ends the text. Results leave
// on the result channel (res_valid, res_stall and the result fields): each
// emitted token as a run of byte items with token_end on its final byte, and
// an end item with the token count for every zero byte.
// Word bytes and bytes that emit nothing do not hold off input. A byte that emits
// a token holds off input while the buffer is read out, one entry per cycle while
// the receiver does not stall; an end item holds it until loaded, and after a token
// waits for the last byte to leave the read stage. Token bytes pass the read stage
// into the output register; an end item is loaded into it directly. When the
// receiver stalls, the output register and the memory read stage hold their items
// and readout pauses; word bytes are still taken while a finished result waits.
// Reset clears the word length, the token count and the output valid, and sets
// token_limit to 65535; the buffer needs no clear. token_limit is written through
// cfg_we and cfg_wdata; the user must write it only while the block is idle, as
// the block itself does not enforce this.
`default_nettype none

module word_tokenizer_stream_core #(
	parameter int WORD_CAPACITY = wts_pkg::WORD_CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        text_valid,
	output logic                        text_stall,
	input  logic [wts_pkg::BYTE_W-1:0]  text_byte,
	input  logic                        cfg_we,
	input  logic [wts_pkg::COUNT_W-1:0] cfg_wdata,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        item_kind,
	output logic [wts_pkg::BYTE_W-1:0]  token_byte,
	output logic                        token_end,
	output logic [wts_pkg::COUNT_W-1:0] tokens_emitted,
	output logic                        run_last
);

	import wts_pkg::*;

	localparam int DEPTH  = WORD_CAPACITY - 1;
	localparam int ADDR_W = $clog2(DEPTH);

	logic              mem_wr_en;
	logic [ADDR_W-1:0] mem_wr_addr;
	logic [BYTE_W-1:0] mem_wr_data;
	logic              mem_rd_en;
	logic [ADDR_W-1:0] mem_rd_addr;
	logic [BYTE_W-1:0] mem_rd_data;

	// Sequencer and output register.
	wts_ctrl #(
		.WORD_CAPACITY(WORD_CAPACITY)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_valid     (text_valid),
		.text_stall     (text_stall),
		.text_byte      (text_byte),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.mem_wr_en      (mem_wr_en),
		.mem_wr_addr    (mem_wr_addr),
		.mem_wr_data    (mem_wr_data),
		.mem_rd_en      (mem_rd_en),
		.mem_rd_addr    (mem_rd_addr),
		.mem_rd_data    (mem_rd_data),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.item_kind      (item_kind),
		.token_byte     (token_byte),
		.token_end      (token_end),
		.tokens_emitted (tokens_emitted),
		.run_last       (run_last)
	);

	// Word buffer memory.
	wts_word_mem #(
		.DEPTH  (DEPTH),
		.DATA_W (BYTE_W)
	) u_word_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/wts_word_mem.sv =====
// Word buffer: single write port, single registered read port memory.
`default_nettype none

module wts_word_mem #(
	parameter int DEPTH  = 31,
	parameter int DATA_W = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] word_mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			word_mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data register holds its value while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= word_mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wts_ctrl.sv =====
// Tokenizer sequencer: word collection, token readout and the output register.
`default_nettype none

module wts_ctrl #(
	parameter int WORD_CAPACITY = wts_pkg::WORD_CAPACITY_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// Input channel
	input  logic                                      text_valid,
	output logic                                      text_stall,
	input  logic [wts_pkg::BYTE_W-1:0]                text_byte,
	// Configuration
	input  logic                                      cfg_we,
	input  logic [wts_pkg::COUNT_W-1:0]               cfg_wdata,
	// Word buffer
	output logic                                      mem_wr_en,
	output logic [$clog2(WORD_CAPACITY-1)-1:0]        mem_wr_addr,
	output logic [wts_pkg::BYTE_W-1:0]                mem_wr_data,
	output logic                                      mem_rd_en,
	output logic [$clog2(WORD_CAPACITY-1)-1:0]        mem_rd_addr,
	input  logic [wts_pkg::BYTE_W-1:0]                mem_rd_data,
	// Result channel
	output logic                                      res_valid,
	input  logic                                      res_stall,
	output logic                                      item_kind,
	output logic [wts_pkg::BYTE_W-1:0]                token_byte,
	output logic                                      token_end,
	output logic [wts_pkg::COUNT_W-1:0]               tokens_emitted,
	output logic                                      run_last
);

	import wts_pkg::*;

	localparam int DEPTH  = WORD_CAPACITY - 1;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = $clog2(WORD_CAPACITY);
	localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);
	localparam logic [LEN_W-1:0] MIN_L   = LEN_W'(MIN_TOKEN_BYTES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_END
	} state_t;

	state_t             state_q;
	logic [LEN_W-1:0]   word_len_q;
	logic [LEN_W-1:0]   rd_idx_q;
	logic [COUNT_W-1:0] token_count_q;
	logic [COUNT_W-1:0] token_limit_q;
	logic               text_end_q;

	// Read stage: the memory data register plus the fields that go with it.
	logic               valid_s1;
	logic               end_s1;
	logic               last_s1;
	logic [COUNT_W-1:0] count_s1;

	// Output register.
	logic               out_valid_q;
	logic               out_kind_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_end_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_last_q;

	logic text_accept;
	logic word_byte;
	logic zero_byte;
	logic emit_word;
	logic out_free;
	logic s1_move;
	logic end_load;
	logic rd_issue;
	logic rd_final;

	// Input decode and handshake.
	assign text_stall  = (state_q != ST_IDLE);
	assign text_accept = text_valid && !text_stall;
	assign word_byte   = is_word_byte(text_byte);
	assign zero_byte   = (text_byte == TEXT_END_BYTE);
	assign emit_word   = (word_len_q > MIN_L) && (token_count_q < token_limit_q);

	// Readout flow: the read stage advances whenever the output register frees up.
	assign out_free = !out_valid_q || !res_stall;
	assign s1_move  = valid_s1 && out_free;
	assign end_load = (state_q == ST_END) && !valid_s1 && out_free;
	assign rd_issue = (state_q == ST_READ) && (!valid_s1 || out_free);
	assign rd_final = ((rd_idx_q + LEN_W'(1)) == word_len_q);

	// Memory ports: writes while collecting, reads while emitting.
	assign mem_wr_en   = text_accept && word_byte && (word_len_q < DEPTH_L);
	assign mem_wr_addr = word_len_q[ADDR_W-1:0];
	assign mem_wr_data = to_lower(text_byte);
	assign mem_rd_en   = rd_issue;
	assign mem_rd_addr = rd_idx_q[ADDR_W-1:0];

	// Sequencer state, counters and valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			word_len_q    <= '0;
			rd_idx_q      <= '0;
			token_count_q <= '0;
			token_limit_q <= TOKEN_LIMIT_RST;
			text_end_q    <= 1'b0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				token_limit_q <= cfg_wdata;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (text_accept) begin
						if (word_byte) begin
							if (word_len_q < DEPTH_L) begin
								word_len_q <= word_len_q + LEN_W'(1);
							end
						end else if (emit_word) begin
							token_count_q <= token_count_q + COUNT_W'(1);
							rd_idx_q      <= '0;
							text_end_q    <= zero_byte;
							state_q       <= ST_READ;
						end else begin
							word_len_q <= '0;
							if (zero_byte) begin
								state_q <= ST_END;
							end
						end
					end
				end
				ST_READ: begin
					if (rd_issue) begin
						rd_idx_q <= rd_idx_q + LEN_W'(1);
						if (rd_final) begin
							word_len_q <= '0;
							state_q    <= text_end_q ? ST_END : ST_IDLE;
						end
					end
				end
				ST_END: begin
					if (end_load) begin
						token_count_q <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Read stage occupancy.
			if (rd_issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end

			// Output register occupancy.
			if (s1_move || end_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Read stage and output register payload.
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			end_s1   <= rd_final;
			last_s1  <= rd_final && !text_end_q;
			count_s1 <= token_count_q;
		end
		if (s1_move) begin
			out_kind_q  <= KIND_TOKEN;
			out_byte_q  <= mem_rd_data;
			out_end_q   <= end_s1;
			out_count_q <= count_s1;
			out_last_q  <= last_s1;
		end else if (end_load) begin
			out_kind_q  <= KIND_END;
			out_byte_q  <= '0;
			out_end_q   <= 1'b0;
			out_count_q <= token_count_q;
			out_last_q  <= 1'b1;
		end
	end

	assign res_valid      = out_valid_q;
	assign item_kind      = out_kind_q;
	assign token_byte     = out_byte_q;
	assign token_end      = out_end_q;
	assign tokens_emitted = out_count_q;
	assign run_last       = out_last_q;

`ifndef ASSERT_OFF
	// The buffer is never read and written in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_rd_en |-> !mem_wr_en)
		else $error("word buffer read and write in the same cycle");

	// The held word never exceeds the buffer depth.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		word_len_q <= DEPTH_L)
		else $error("word length exceeds buffer depth");

	// A token readout always follows a counted token.
	a_read_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (token_count_q != '0) && (word_len_q > MIN_L))
		else $error("readout without a counted token");

	// The end item never overtakes token bytes still in the read stage.
	a_end_order: assert property (@(posedge clk) disable iff (!arst_n)
		end_load |-> !valid_s1 && !s1_move)
		else $error("end item loaded ahead of token bytes");

	// A read stage entry that cannot move is held to the next cycle.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> valid_s1 && $stable(end_s1) && $stable(count_s1))
		else $error("read stage entry lost under stall");
`endif

endmodule

`default_nettype wire
